// File: src/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and constants of the bump / first-fit heap allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

    // request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_NEW     = 2'd0;
    localparam logic [1:0] STAT_REUSED  = 2'd1;
    localparam logic [1:0] STAT_OOM     = 2'd2;
    localparam logic [1:0] STAT_IGNORED = 2'd3;

    // configuration register indexes
    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_BYTES = 1'b1;

    typedef struct packed {
        logic        is_free;
        logic [31:0] data_size;
        logic [31:0] start;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_FREE_END,
        ST_DONE
    } state_t;

endpackage

// File: src/bffa_ram.sv
// ----------------------------------------------------------------------------
// bffa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/bump_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// bump_first_fit_allocator
// Heap allocator: bump placement with first-fit reuse of freed blocks.
// ----------------------------------------------------------------------------
// One request is worked on at a time. An allocate request that fits at the
// end of the heap, with room left in the table, skips the table search. An
// allocate request that falls back to the first-fit search, and every free
// request, walk the block table (up to 64 entries) one entry per cycle
// through the single read port of the table memory; a free whose address
// lies outside the heap, or any request on an empty table, skips the walk.
// The next request is taken once the result sits in the output register.
// Writing heap_base or heap_bytes empties the table.
module bump_first_fit_allocator
    import bffa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // request_size, release_address
    input  logic        s_tuser,   // action
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // granted_address
    output logic [1:0]  m_tuser,   // status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t state_reg, state_next;

    logic [31:0]      heap_base_reg, heap_bytes_reg, heap_end_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      nf_reg, nf_next;

    logic             action_reg;
    logic [31:0]      size_reg, addr_reg;

    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;

    logic             found_reg, found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [31:0]      hit_start_reg, hit_start_next;
    logic [31:0]      hit_size_reg, hit_size_next;

    logic [31:0]      res_addr_reg, res_addr_next;
    logic [1:0]       res_status_reg, res_status_next;

    logic             m_tvalid_reg;
    logic [31:0]      m_tdata_reg;
    logic [1:0]       m_tuser_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    entry_t           ram_wdata, rd_entry;
    logic [ENTRY_W-1:0] ram_rdata;

    logic             cfg_we;
    logic [32:0]      end_sum;
    logic [33:0]      bump_sum;
    logic             fits, table_full, in_range, issue_more, last_rd;
    logic             alloc_hit, free_match, pop_hit, out_load;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_HEAP_BYTES) ? heap_bytes_reg : heap_base_reg;

    assign end_sum = {1'b0, heap_base_reg} + {1'b0, heap_bytes_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg  <= '0;
            heap_bytes_reg <= '0;
        end else if (cfg_we) begin
            if (paddr[2] == REG_HEAP_BASE) begin
                heap_base_reg <= pwdata;
            end else begin
                heap_bytes_reg <= pwdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        heap_end_reg <= end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
    end

    // block table
    bffa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = ram_rdata;

    // decisions
    assign bump_sum   = 34'(nf_reg) + 34'(size_reg) + 34'(HEADER_BYTES);
    assign fits       = bump_sum <= 34'(heap_end_reg);
    assign table_full = count_reg == CNT_W'(MAX_BLOCKS);
    assign in_range   = (addr_reg >= heap_base_reg) && (addr_reg <= heap_end_reg);
    assign issue_more = issue_reg < count_reg;
    assign last_rd    = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg;
    assign alloc_hit  = rd_valid_reg && rd_entry.is_free &&
                        (rd_entry.data_size >= size_reg);
    assign free_match = rd_valid_reg &&
                        (({1'b0, rd_entry.start} + 33'(HEADER_BYTES)) == {1'b0, addr_reg});
    assign pop_hit    = (CNT_W'(hit_idx_reg) + CNT_W'(1)) == count_reg;
    assign out_load   = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (action_reg == ACT_ALLOC && fits && !table_full) begin
                    state_next = ST_DONE;
                end else if (count_reg == '0) begin
                    state_next = ST_DONE;
                end else if (action_reg == ACT_FREE && !in_range) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (action_reg == ACT_ALLOC) begin
                    if (alloc_hit || (rd_valid_reg && last_rd)) begin
                        state_next = ST_DONE;
                    end
                end else if (rd_valid_reg && last_rd) begin
                    state_next = ST_FREE_END;
                end
            end
            ST_FREE_END: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb begin
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_wdata       = '0;
        ram_raddr       = issue_reg[IDX_W-1:0];
        count_next      = count_reg;
        nf_next         = nf_reg;
        issue_next      = issue_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = issue_reg[IDX_W-1:0];
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_start_next  = hit_start_reg;
        hit_size_next   = hit_size_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            ST_CHECK: begin
                issue_next    = '0;
                found_next    = 1'b0;
                res_addr_next = '0;
                if (action_reg == ACT_ALLOC) begin
                    res_status_next = STAT_OOM;
                    if (fits && !table_full) begin
                        ram_we          = 1'b1;
                        ram_waddr       = count_reg[IDX_W-1:0];
                        ram_wdata       = '{is_free: 1'b0, data_size: size_reg, start: nf_reg};
                        count_next      = count_reg + CNT_W'(1);
                        nf_next         = bump_sum[31:0];
                        res_addr_next   = nf_reg + 32'(HEADER_BYTES);
                        res_status_next = STAT_NEW;
                    end
                end else begin
                    res_status_next = STAT_IGNORED;
                end
            end
            ST_SCAN: begin
                if (issue_more) begin
                    rd_valid_next = 1'b1;
                    issue_next    = issue_reg + CNT_W'(1);
                end
                if (action_reg == ACT_ALLOC) begin
                    if (alloc_hit) begin
                        ram_we          = 1'b1;
                        ram_waddr       = rd_idx_reg;
                        ram_wdata       = '{is_free: 1'b0, data_size: rd_entry.data_size,
                                            start: rd_entry.start};
                        res_addr_next   = rd_entry.start + 32'(HEADER_BYTES);
                        res_status_next = STAT_REUSED;
                    end
                end else if (free_match) begin
                    found_next     = 1'b1;
                    hit_idx_next   = rd_idx_reg;
                    hit_start_next = rd_entry.start;
                    hit_size_next  = rd_entry.data_size;
                end
            end
            ST_FREE_END: begin
                if (found_reg) begin
                    res_status_next = STAT_REUSED;
                    if (pop_hit) begin
                        count_next = CNT_W'(hit_idx_reg);
                        nf_next    = (hit_idx_reg == '0) ? heap_base_reg : hit_start_reg;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = hit_idx_reg;
                        ram_wdata = '{is_free: 1'b1, data_size: hit_size_reg,
                                      start: hit_start_reg};
                    end
                end
            end
            default: begin
            end
        endcase
        // a register write restarts the heap
        if (cfg_we) begin
            count_next = '0;
            nf_next    = (paddr[2] == REG_HEAP_BASE) ? pwdata : heap_base_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            nf_reg       <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            issue_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            nf_reg       <= nf_next;
            rd_valid_reg <= rd_valid_next;
            found_reg    <= found_next;
            issue_reg    <= issue_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_start_reg  <= hit_start_next;
        hit_size_reg   <= hit_size_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        if (state_reg == ST_IDLE && s_tvalid) begin
            action_reg <= s_tuser;
            size_reg   <= s_tdata[31:0];
            addr_reg   <= s_tdata[63:32];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= res_addr_reg;
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: src/bffa_checker.sv
// ----------------------------------------------------------------------------
// bffa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bffa_checker
    import bffa_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // failed or ignored requests grant nothing
    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_OOM || m_tuser == STAT_IGNORED) |-> m_tdata == 32'd0)
        else $error("granted address not zero on failed request");

    // one request at a time
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in flight");

    // no result the cycle after a request is taken
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    // stalled result holds
    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind bump_first_fit_allocator bffa_checker u_bffa_checker (.*);
